// File: sv/smallest_subtour_finder_top_macros.svh
// Assertion helpers used by the subtour finder datapath.
`ifndef SMALLEST_SUBTOUR_FINDER_TOP_MACROS_SVH
`define SMALLEST_SUBTOUR_FINDER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock out of reset.
`define SST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every clock out of reset.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = 5;   // node index width
    localparam int CNT_W     = 6;   // node count / length width
    localparam int ROW_W     = 32;  // adjacency row width
    localparam int OUT_W     = 16;  // output tdata, padded to bytes

    localparam logic [CNT_W-1:0] RESET_NODE_COUNT = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0] RESET_BEST_LEN   = CNT_W'(MAX_NODES + 1);

    typedef struct packed {
        logic store_row;     // accepted input row
        logic start_search;  // accepted row was the last one
        logic step;          // visit one node of the walk
        logic emit_load;     // load next result into output register
    } t_cmd;

    typedef struct packed {
        logic search_done;   // this step visits the final node
        logic emit_last;     // next loaded result ends the subtour
        logic out_valid;     // output register holds an item
    } t_status;

    // Index of lowest set bit; zero when none is set.
    function automatic logic [NODE_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [NODE_W-1:0] res;
        res = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                res = NODE_W'(j);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/smallest_subtour_finder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Smallest subtour finder.
// Input stream: one adjacency row per item (tdata bit j = edge to node j), tlast on the
// final row. Rows load one per cycle. After the last row the block walks the graph one
// node per cycle (one row lookup and lowest-bit pick per cycle), then streams out the
// nodes of the shortest walk in visit order, one item per cycle while m_axis_tready is
// high, tlast on the final node. s_axis_tready is low during the walk and while results
// are still being loaded into the output register; rows of the next matrix are taken
// once the last result is in the output register. A stalled receiver holds the output
// register; emission resumes when m_axis_tready returns. node_count (clamped to 1..32
// in use) is written through i_cfg_we / i_cfg_wdata; the user must write it only while
// idle, the block itself does not enforce this. Reset (synchronous, active low) sets
// node_count to 32, clears the row counter and drops m_axis_tvalid.
module smallest_subtour_finder_top
    import sst_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [ROW_W-1:0] s_axis_tdata,   // [31:0] row_bits
    input  wire logic             s_axis_tlast,   // last_row
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [4:0] tour_node, [10:5] tour_length
    output logic                  m_axis_tlast    // last_node
);

    t_cmd    cmd;
    t_status status;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sst_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_row       (s_axis_tdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: sv/sst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl
    import sst_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_s_tlast,
    output logic         o_s_tready,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd              = '0;
        o_s_tready         = (r_state == ST_LOAD);
        o_cmd.store_row    = (r_state == ST_LOAD) && i_s_tvalid;
        o_cmd.start_search = o_cmd.store_row && i_s_tlast;
        o_cmd.step         = (r_state == ST_SEARCH);
        o_cmd.emit_load    = (r_state == ST_EMIT) && (!i_status.out_valid || i_m_tready);

        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (o_cmd.start_search) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_status.search_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (o_cmd.emit_load && i_status.emit_last) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/sst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "smallest_subtour_finder_top_macros.svh"

module sst_datapath
    import sst_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic             i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_W-1:0]      o_m_tdata,   // [4:0] tour_node, [10:5] tour_length
    output logic                  o_m_tlast    // last_node
);

    logic [ROW_W-1:0]  r_adj [MAX_NODES];
    logic [NODE_W-1:0] r_walk [MAX_NODES];

    logic [CNT_W-1:0]  r_node_count;
    logic [CNT_W-1:0]  r_row_cnt;
    logic [ROW_W-1:0]  r_visited;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_start;
    logic [NODE_W-1:0] r_cur;
    logic [NODE_W-1:0] r_best_start;
    logic [CNT_W-1:0]  r_best_len;
    logic [NODE_W-1:0] r_k;

    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic [CNT_W-1:0]  r_out_len;
    logic              r_out_last;

    logic [CNT_W-1:0]  n_eff;
    logic [ROW_W-1:0]  live;
    logic [ROW_W-1:0]  vis_next;
    logic [ROW_W-1:0]  cand;
    logic [ROW_W-1:0]  unvisited;
    logic [CNT_W-1:0]  pos_next;
    logic [CNT_W-1:0]  walk_len;
    logic              walk_end;
    logic [NODE_W-1:0] emit_idx;

    // Node count clamped to 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            n_eff = CNT_W'(MAX_NODES);
        end else begin
            n_eff = r_node_count;
        end
        for (int j = 0; j < ROW_W; j++) begin
            live[j] = (CNT_W'(j) < n_eff);
        end
    end

    assign vis_next  = r_visited | (ROW_W'(1) << r_cur);
    assign cand      = r_adj[r_cur] & ~vis_next & live;
    assign unvisited = ~vis_next & live;
    assign pos_next  = r_pos + CNT_W'(1);
    assign walk_end  = (cand == '0) || (pos_next >= n_eff);
    assign walk_len  = pos_next - r_start;
    assign emit_idx  = r_best_start + r_k;

    assign o_status.search_done = walk_end && (pos_next >= n_eff);
    assign o_status.emit_last   = ({1'b0, r_k} + CNT_W'(1)) == r_best_len;
    assign o_status.out_valid   = r_out_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_W - CNT_W - NODE_W)'(0), r_out_len, r_out_node};
    assign o_m_tlast  = r_out_last;

    // Storage arrays and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_row && (r_row_cnt < CNT_W'(MAX_NODES))) begin
            r_adj[r_row_cnt[NODE_W-1:0]] <= i_row;
        end
        if (i_cmd.step) begin
            r_walk[r_pos[NODE_W-1:0]] <= r_cur;
        end
        if (i_cmd.emit_load) begin
            r_out_node <= r_walk[emit_idx];
            r_out_len  <= r_best_len;
            r_out_last <= o_status.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= RESET_NODE_COUNT;
            r_row_cnt    <= '0;
            r_visited    <= '0;
            r_pos        <= '0;
            r_start      <= '0;
            r_cur        <= '0;
            r_best_start <= '0;
            r_best_len   <= RESET_BEST_LEN;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end

            if (i_cmd.start_search) begin
                r_row_cnt    <= '0;
                r_visited    <= '0;
                r_pos        <= '0;
                r_start      <= '0;
                r_cur        <= '0;
                r_best_start <= '0;
                r_best_len   <= n_eff + CNT_W'(1);
                r_k          <= '0;
            end else if (i_cmd.store_row && (r_row_cnt < CNT_W'(MAX_NODES))) begin
                r_row_cnt <= r_row_cnt + CNT_W'(1);
            end

            if (i_cmd.step) begin
                r_visited <= vis_next;
                r_pos     <= pos_next;
                if (walk_end) begin
                    // next walk starts at the lowest unvisited node
                    r_start <= pos_next;
                    r_cur   <= lowest_set(unvisited);
                    if (walk_len < r_best_len) begin
                        r_best_len   <= walk_len;
                        r_best_start <= r_start[NODE_W-1:0];
                    end
                end else begin
                    r_cur <= lowest_set(cand);
                end
            end

            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
                r_k         <= r_k + NODE_W'(1);
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SST_ASSERT_IMPL(a_step_unvisited, i_cmd.step, !r_visited[r_cur])
    `SST_ASSERT_IMPL(a_step_in_range, i_cmd.step, (r_pos < n_eff) && live[r_cur])
    `SST_ASSERT_IMPL(a_emit_in_range, i_cmd.emit_load, {1'b0, r_k} < r_best_len)
    `SST_ASSERT_NEXT(a_best_found, i_cmd.step && o_status.search_done,
        (r_best_len != '0) && (r_best_len <= n_eff))

endmodule

`default_nettype wire
